// ===== hdl/rcfm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfm_pkg: shared types and constants
// Register map, status codes, configuration and region structs, and the
// small helper functions used by the colour search block.
// ----------------------------------------------------------------------------
package rcfm_pkg;

  // Largest frame dimension and the widths that follow from it
  localparam int MAX_DIM = 4096;
  localparam int POS_W   = $clog2(MAX_DIM);   // column / row position
  localparam int DIM_W   = POS_W + 1;         // dimension, holds MAX_DIM itself
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 3 * CHAN_W;
  localparam int ADDR_W  = 5;                 // eight 32-bit registers
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_REGION_X     = 3'd2,
    REG_REGION_Y     = 3'd3,
    REG_REGION_W     = 3'd4,
    REG_REGION_H     = 3'd5,
    REG_TARGET_COLOR = 3'd6,
    REG_TOLERANCE    = 3'd7
  } reg_idx_t;

  // Reset values of the frame size
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(480);

  // Result status codes
  localparam logic [STAT_W-1:0] ST_MATCH      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_MATCH   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_REGION = 2'd2;

  // Configuration register contents
  typedef struct packed {
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [POS_W-1:0]   region_x;
    logic [POS_W-1:0]   region_y;
    logic [DIM_W-1:0]   region_w;
    logic [DIM_W-1:0]   region_h;
    logic [COLOR_W-1:0] target_color;
    logic [CHAN_W-1:0]  tolerance;
  } cfg_t;

  // Normalised search region, all bounds inclusive
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] x_first;
    logic [POS_W-1:0] x_last;
    logic [POS_W-1:0] y_first;
    logic [POS_W-1:0] y_last;
    logic [POS_W-1:0] col_last;
    logic [POS_W-1:0] row_last;
  } region_t;

  // Frame dimension: zero acts as one, oversize acts as MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // One colour channel within tolerance of the target
  function automatic logic chan_close(input logic [CHAN_W-1:0] a,
                                      input logic [CHAN_W-1:0] b,
                                      input logic [CHAN_W-1:0] tol);
    logic [CHAN_W-1:0] d;
    d = (a >= b) ? a - b : b - a;
    return d <= tol;
  endfunction

endpackage

// ===== hdl/rcfm_if.sv =====
// ----------------------------------------------------------------------------
// rcfm_if: stream channels of the colour search block
// Pixel channel (RGB888) and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rcfm_pixel_if import rcfm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rcfm_result_if import rcfm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  match_x;
  logic [POS_W-1:0]  match_y;

  modport source (output valid, status, match_x, match_y, input ready);
  modport sink   (input valid, status, match_x, match_y, output ready);
endinterface

// ===== hdl/rcfm_regs.sv =====
// ----------------------------------------------------------------------------
// rcfm_regs: configuration register file
// APB-style slave holding the frame size, search region, target colour and
// tolerance. Zero wait states.
// ----------------------------------------------------------------------------
module rcfm_regs import rcfm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= FRAME_WIDTH_RST;
      cfg.frame_height <= FRAME_HEIGHT_RST;
      cfg.region_x     <= '0;
      cfg.region_y     <= '0;
      cfg.region_w     <= '0;
      cfg.region_h     <= '0;
      cfg.target_color <= '0;
      cfg.tolerance    <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[DIM_W-1:0];
        REG_REGION_X:     cfg.region_x     <= pwdata[POS_W-1:0];
        REG_REGION_Y:     cfg.region_y     <= pwdata[POS_W-1:0];
        REG_REGION_W:     cfg.region_w     <= pwdata[DIM_W-1:0];
        REG_REGION_H:     cfg.region_h     <= pwdata[DIM_W-1:0];
        REG_TARGET_COLOR: cfg.target_color <= pwdata[COLOR_W-1:0];
        REG_TOLERANCE:    cfg.tolerance    <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    case (idx)
      REG_FRAME_WIDTH:  prdata = DATA_W'(cfg.frame_width);
      REG_FRAME_HEIGHT: prdata = DATA_W'(cfg.frame_height);
      REG_REGION_X:     prdata = DATA_W'(cfg.region_x);
      REG_REGION_Y:     prdata = DATA_W'(cfg.region_y);
      REG_REGION_W:     prdata = DATA_W'(cfg.region_w);
      REG_REGION_H:     prdata = DATA_W'(cfg.region_h);
      REG_TARGET_COLOR: prdata = DATA_W'(cfg.target_color);
      REG_TOLERANCE:    prdata = DATA_W'(cfg.tolerance);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== hdl/rcfm_region.sv =====
// ----------------------------------------------------------------------------
// rcfm_region: search region normaliser
// Turns the raw region registers into inclusive bounds clipped to the frame,
// plus the last column and row of the frame. Result is registered.
// ----------------------------------------------------------------------------
module rcfm_region import rcfm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  output region_t region
);

  logic [DIM_W-1:0] fw, fh;
  logic [DIM_W-1:0] rx, ry;
  logic [DIM_W-1:0] avail_x, avail_y;
  logic [DIM_W-1:0] w, h;
  logic [DIM_W-1:0] x_end, y_end;
  region_t          region_next;

  // Clamp frame size, check region start, clip width and height
  always_comb begin
    fw      = clamp_dim(cfg.frame_width);
    fh      = clamp_dim(cfg.frame_height);
    rx      = {1'b0, cfg.region_x};
    ry      = {1'b0, cfg.region_y};
    avail_x = fw - rx;
    avail_y = fh - ry;
    w       = (cfg.region_w == '0 || cfg.region_w > avail_x) ? avail_x : cfg.region_w;
    h       = (cfg.region_h == '0 || cfg.region_h > avail_y) ? avail_y : cfg.region_h;
    x_end   = rx + w - DIM_W'(1);
    y_end   = ry + h - DIM_W'(1);

    region_next.valid    = (rx < fw) && (ry < fh);
    region_next.x_first  = cfg.region_x;
    region_next.x_last   = x_end[POS_W-1:0];
    region_next.y_first  = cfg.region_y;
    region_next.y_last   = y_end[POS_W-1:0];
    region_next.col_last = POS_W'(fw - DIM_W'(1));
    region_next.row_last = POS_W'(fh - DIM_W'(1));
  end

  // Reset value matches the reset register contents: full 640x480 frame
  always_ff @(posedge clk) begin
    if (rst) begin
      region.valid    <= 1'b1;
      region.x_first  <= '0;
      region.x_last   <= POS_W'(FRAME_WIDTH_RST - DIM_W'(1));
      region.y_first  <= '0;
      region.y_last   <= POS_W'(FRAME_HEIGHT_RST - DIM_W'(1));
      region.col_last <= POS_W'(FRAME_WIDTH_RST - DIM_W'(1));
      region.row_last <= POS_W'(FRAME_HEIGHT_RST - DIM_W'(1));
    end else begin
      region <= region_next;
    end
  end

endmodule

// ===== hdl/rcfm_scan.sv =====
// ----------------------------------------------------------------------------
// rcfm_scan: raster scan and first-match capture
// Input register for one pixel, position counters, hit capture and the
// result register. One pixel per cycle unless a frame end waits on a result.
// ----------------------------------------------------------------------------
module rcfm_scan import rcfm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  region_t              region,
  rcfm_pixel_if.sink           pixel,
  rcfm_result_if.source        result
);

  // Input register
  logic              pix_valid;
  logic [CHAN_W-1:0] pix_r, pix_g, pix_b;

  // Scan state
  logic [POS_W-1:0]  column_count, row_count;
  logic              hit_seen;
  logic [POS_W-1:0]  hit_column, hit_row;

  // Result register
  logic              res_valid;
  logic [STAT_W-1:0] res_status;
  logic [POS_W-1:0]  res_x, res_y;

  logic              in_region, color_ok, hit_now;
  logic              end_row, end_frame;
  logic              pix_fire, pix_take;
  logic [STAT_W-1:0] status_next;
  logic [POS_W-1:0]  x_next, y_next;

  // Per-pixel decisions
  always_comb begin
    in_region = region.valid &&
                column_count >= region.x_first && column_count <= region.x_last &&
                row_count >= region.y_first && row_count <= region.y_last;
    color_ok  = chan_close(pix_r, cfg.target_color[3*CHAN_W-1:2*CHAN_W], cfg.tolerance) &&
                chan_close(pix_g, cfg.target_color[2*CHAN_W-1:CHAN_W], cfg.tolerance) &&
                chan_close(pix_b, cfg.target_color[CHAN_W-1:0], cfg.tolerance);
    hit_now   = !hit_seen && in_region && color_ok;
    end_row   = column_count >= region.col_last;
    end_frame = end_row && row_count >= region.row_last;

    if (!region.valid) begin
      status_next = ST_BAD_REGION;
      x_next      = '0;
      y_next      = '0;
    end else if (hit_now) begin
      status_next = ST_MATCH;
      x_next      = column_count;
      y_next      = row_count;
    end else if (hit_seen) begin
      status_next = ST_MATCH;
      x_next      = hit_column;
      y_next      = hit_row;
    end else begin
      status_next = ST_NO_MATCH;
      x_next      = '0;
      y_next      = '0;
    end
  end

  // A pixel leaves the input register unless it ends a frame while the
  // result register is still full and stalled
  assign pix_fire    = pix_valid && !(end_frame && res_valid && !result.ready);
  assign pix_take    = pixel.valid && pixel.ready;
  assign pixel.ready = !pix_valid || pix_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (pixel.ready) begin
      pix_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take) begin
      pix_r <= pixel.red;
      pix_g <= pixel.green;
      pix_b <= pixel.blue;
    end
  end

  // Position counters and hit capture
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      hit_seen     <= 1'b0;
      hit_column   <= '0;
      hit_row      <= '0;
    end else if (pix_fire) begin
      if (end_frame) begin
        column_count <= '0;
        row_count    <= '0;
        hit_seen     <= 1'b0;
        hit_column   <= '0;
        hit_row      <= '0;
      end else begin
        if (end_row) begin
          column_count <= '0;
          row_count    <= row_count + POS_W'(1);
        end else begin
          column_count <= column_count + POS_W'(1);
        end
        if (hit_now) begin
          hit_seen   <= 1'b1;
          hit_column <= column_count;
          hit_row    <= row_count;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pix_fire && end_frame) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire && end_frame) begin
      res_status <= status_next;
      res_x      <= x_next;
      res_y      <= y_next;
    end
  end

  assign result.valid   = res_valid;
  assign result.status  = res_status;
  assign result.match_x = res_x;
  assign result.match_y = res_y;

endmodule

// ===== hdl/region_color_first_match.sv =====
// ----------------------------------------------------------------------------
// region_color_first_match: first colour match inside a region of a frame
// Scans a raster-order RGB888 stream and reports, once per frame, the first
// pixel in the search region whose channels all lie within the tolerance.
//
//   channel  dir  handshake      payload
//   pixel    in   valid/ready    red, green, blue (8 bit each)
//   result   out  valid/ready    status (2), match_x (12), match_y (12)
//   apb      in   psel/penable   8 registers, byte address 4*index
//
// One pixel per clock sustained while no result is held off; the last pixel of
// a frame passes the input register, then the result register takes the report.
// Region bounds follow a register write in the next cycle.
// A frame-ending pixel waits in the input register while an earlier result
// is untaken, which stalls the pixel input; nothing else stalls it.
// Reset (rst, synchronous) clears counters, hit and valid flags, resets config.
// ----------------------------------------------------------------------------
module region_color_first_match import rcfm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  rcfm_pixel_if.sink        pixel,
  rcfm_result_if.source     result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  region_t region;

  rcfm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rcfm_region u_region (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .region (region)
  );

  rcfm_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .region (region),
    .pixel  (pixel),
    .result (result)
  );

  // Only a match carries coordinates
  a_nonmatch_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != ST_MATCH |->
      result.match_x == '0 && result.match_y == '0)
    else $error("non-match result with nonzero coordinates");

  // A valid region stays ordered and inside the frame
  a_region_clip: assert property (@(posedge clk) disable iff (rst)
    region.valid |->
      region.x_first <= region.x_last && region.x_last <= region.col_last &&
      region.y_first <= region.y_last && region.y_last <= region.row_last)
    else $error("normalised region not clipped to frame");

  // A stalled result holds its transfer unchanged
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=>
      result.valid && $stable(result.status) &&
      $stable(result.match_x) && $stable(result.match_y))
    else $error("stalled result changed or dropped");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for region_color_first_match
// Streams RGB888 frames through the pixel channel and writes the search
// registers over APB between phases. A scoreboard class predicts the
// per-frame report from its own copy of the registers and scan state, and
// checks every result transfer against the oldest prediction. Stimulus is
// a short directed set, random small frames with mid-frame register
// changes and a long result back-pressure stretch.
// ----------------------------------------------------------------------------
module tb;
  import rcfm_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  match_x;
    logic [POS_W-1:0]  match_y;
  } report_t;

  // Scoreboard: predicts each frame report and checks the reported ones
  class match_report_board;
    int unsigned frame_width, frame_height, region_x, region_y;
    int unsigned region_w, region_h, target_color, tolerance;
    int unsigned col, row, hit_col, hit_row;
    bit          hit_seen;
    report_t     reports_due[$];
    int          mismatches;

    function new();
      frame_width  = 640;
      frame_height = 480;
      region_x     = 0;
      region_y     = 0;
      region_w     = 0;
      region_h     = 0;
      target_color = 0;
      tolerance    = 0;
      col          = 0;
      row          = 0;
      hit_col      = 0;
      hit_row      = 0;
      hit_seen     = 1'b0;
      mismatches   = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH:  frame_width  = 32'(val[12:0]);
        REG_FRAME_HEIGHT: frame_height = 32'(val[12:0]);
        REG_REGION_X:     region_x     = 32'(val[11:0]);
        REG_REGION_Y:     region_y     = 32'(val[11:0]);
        REG_REGION_W:     region_w     = 32'(val[12:0]);
        REG_REGION_H:     region_h     = 32'(val[12:0]);
        REG_TARGET_COLOR: target_color = 32'(val[23:0]);
        REG_TOLERANCE:    tolerance    = 32'(val[7:0]);
        default: ;
      endcase
    endfunction

    function bit chan_near(int unsigned a, int unsigned t);
      int d;
      d = int'(a) - int'(t);
      if (d < 0) d = -d;
      return d <= int'(tolerance);
    endfunction

    // Advance the scan by one accepted pixel
    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned fw, fh, w, h;
      bit          ok, end_row;
      report_t     rep;
      fw = (frame_width == 0) ? 1 : ((frame_width > MAX_DIM) ? MAX_DIM : frame_width);
      fh = (frame_height == 0) ? 1 : ((frame_height > MAX_DIM) ? MAX_DIM : frame_height);
      ok = (region_x < fw) && (region_y < fh);
      w = 0;
      h = 0;
      if (ok) begin
        w = (region_w == 0) ? fw - region_x : region_w;
        h = (region_h == 0) ? fh - region_y : region_h;
        if (w > fw - region_x) w = fw - region_x;
        if (h > fh - region_y) h = fh - region_y;
      end
      if (ok && !hit_seen && col >= region_x && col - region_x < w &&
          row >= region_y && row - region_y < h &&
          chan_near(32'(r), (target_color >> 16) & 8'hff) &&
          chan_near(32'(g), (target_color >> 8) & 8'hff) &&
          chan_near(32'(b), target_color & 8'hff)) begin
        hit_seen = 1'b1;
        hit_col  = col;
        hit_row  = row;
      end
      end_row = col >= fw - 1;
      if (end_row && row >= fh - 1) begin
        rep.match_x = '0;
        rep.match_y = '0;
        if (!ok) begin
          rep.status = ST_BAD_REGION;
        end else if (hit_seen) begin
          rep.status  = ST_MATCH;
          rep.match_x = hit_col[POS_W-1:0];
          rep.match_y = hit_row[POS_W-1:0];
        end else begin
          rep.status = ST_NO_MATCH;
        end
        reports_due.push_back(rep);
        col      = 0;
        row      = 0;
        hit_seen = 1'b0;
        hit_col  = 0;
        hit_row  = 0;
      end else if (end_row) begin
        col = 0;
        row = row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void check_report(logic [STAT_W-1:0] st, logic [POS_W-1:0] mx,
                               logic [POS_W-1:0] my);
      report_t want;
      if (reports_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: status %0d x %0d y %0d", st, mx, my);
        mismatches++;
        return;
      end
      want = reports_due.pop_front();
      if (want.status !== st || want.match_x !== mx || want.match_y !== my) begin
        if (mismatches < 10)
          $display("result mismatch: expected status %0d x %0d y %0d, got %0d x %0d y %0d",
                   want.status, want.match_x, want.match_y, st, mx, my);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  rcfm_pixel_if  pix ();
  rcfm_result_if res ();

  match_report_board sb = new();

  int send_idle    = 0;
  int recv_idle    = 0;
  int hold_left    = 0;
  int random_items = 0;

  region_color_first_match DUT (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pix),
    .result  (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side ready: random idling, or a counted hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1)
      sb.check_report(res.status, res.match_x, res.match_y);
  end

  // Idling follows the amount of random stimulus sent so far
  task automatic set_idle_mode();
    if (random_items < 250) begin
      send_idle = 37;
      recv_idle = 76;
    end else if (random_items < 500) begin
      send_idle = 76;
      recv_idle = 37;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  endtask

  // One pixel transfer; valid stays high into the next call
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      pix.valid <= 1'b0;
      @(negedge clk);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    sb.note_pixel(r, g, b);
  endtask

  task automatic pixel_rest();
    @(negedge clk);
    pix.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.reports_due.size() != 0) @(posedge clk);
  endtask

  // Stop sending, let every report arrive and the pipeline empty
  task automatic quiesce();
    pixel_rest();
    wait_drained();
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apb_idle();
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_setup(input int unsigned fw, input int unsigned fh,
                            input int unsigned rx, input int unsigned ry,
                            input int unsigned rw, input int unsigned rh,
                            input int unsigned tgt, input int unsigned tol);
    apb_write(REG_FRAME_WIDTH, fw);
    apb_write(REG_FRAME_HEIGHT, fh);
    apb_write(REG_REGION_X, rx);
    apb_write(REG_REGION_Y, ry);
    apb_write(REG_REGION_W, rw);
    apb_write(REG_REGION_H, rh);
    apb_write(REG_TARGET_COLOR, tgt);
    apb_write(REG_TOLERANCE, tol);
    apb_idle();
  endtask

  // Channel value a little inside or just outside the tolerance band
  function automatic logic [7:0] near_chan(int unsigned t, int unsigned tol);
    int v;
    v = int'(t) + int'($urandom_range(0, 2 * tol + 4)) - int'(tol) - 2;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic send_random_pixel(input int near_pct);
    logic [7:0] r, g, b;
    if ($urandom_range(0, 99) < near_pct) begin
      r = near_chan((sb.target_color >> 16) & 8'hff, sb.tolerance);
      g = near_chan((sb.target_color >> 8) & 8'hff, sb.tolerance);
      b = near_chan(sb.target_color & 8'hff, sb.tolerance);
    end else begin
      r = 8'($urandom_range(0, 255));
      g = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
    end
    send_pixel(r, g, b);
  endtask

  // Random registers: mostly small frames, some oversize and bad regions
  task automatic pick_setup();
    int unsigned fw, fh, efw, efh, rx, ry, rw, rh, tgt, tol;
    case ($urandom_range(0, 19))
      0:       fw = 8191;
      1:       fw = $urandom_range(9, 8191);
      default: fw = $urandom_range(0, 8);
    endcase
    case ($urandom_range(0, 19))
      0:       fh = 4096;
      1:       fh = $urandom_range(6, 8191);
      default: fh = $urandom_range(0, 5);
    endcase
    efw = (fw == 0) ? 1 : ((fw > 4096) ? 4096 : fw);
    efh = (fh == 0) ? 1 : ((fh > 4096) ? 4096 : fh);
    case ($urandom_range(0, 11))
      0:       rx = (efw >= 4096) ? 4095 : $urandom_range(efw, 4095);
      1:       rx = efw - 1;
      default: rx = $urandom_range(0, efw - 1);
    endcase
    case ($urandom_range(0, 11))
      0:       ry = (efh >= 4096) ? 4095 : $urandom_range(efh, 4095);
      1:       ry = efh - 1;
      default: ry = $urandom_range(0, efh - 1);
    endcase
    case ($urandom_range(0, 5))
      0:       rw = 0;
      1:       rw = 8191;
      2:       rw = 4096;
      default: rw = $urandom_range(1, efw + 1);
    endcase
    case ($urandom_range(0, 5))
      0:       rh = 0;
      1:       rh = 8191;
      2:       rh = 4096;
      default: rh = $urandom_range(1, efh + 1);
    endcase
    case ($urandom_range(0, 7))
      0:       tgt = 0;
      1:       tgt = 24'hffffff;
      default: tgt = $urandom_range(0, 24'hffffff);
    endcase
    case ($urandom_range(0, 7))
      0:       tol = 0;
      1:       tol = 255;
      2:       tol = $urandom_range(0, 255);
      default: tol = $urandom_range(0, 24);
    endcase
    load_setup(fw, fh, rx, ry, rw, rh, tgt, tol);
  endtask

  // Random pixels; sometimes stop mid-phase until all reports are in
  task automatic run_phase(input int n);
    for (int k = 0; k < n; k++) begin
      if (k == n / 2 && $urandom_range(0, 2) == 0) begin
        pixel_rest();
        wait_drained();
      end
      send_random_pixel(35);
      random_items++;
      set_idle_mode();
    end
  endtask

  initial begin
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    pix.valid = 1'b0;
    pix.red   = '0;
    pix.green = '0;
    pix.blue  = '0;
    res.ready = 1'b0;
    set_idle_mode();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Match at right edge of a region starting at column 1
    load_setup(3, 2, 1, 0, 0, 0, 24'hffffff, 0);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hff, 8'hfe, 8'hff);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'h00, 8'h00);
    quiesce();

    // Zero frame width acts as one column; full tolerance
    load_setup(0, 2, 0, 0, 0, 0, 0, 255);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'h00, 8'hff, 8'h00);
    quiesce();

    // Hit recorded, then region moved outside the frame mid-frame
    load_setup(2, 2, 0, 0, 0, 0, 0, 255);
    send_pixel(8'h00, 8'h00, 8'h00);
    quiesce();
    apb_write(REG_REGION_X, 3);
    apb_idle();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h80, 8'h80, 8'h80);
    quiesce();

    // Oversize region clipped, near miss by one at zero tolerance
    load_setup(2, 1, 0, 0, 8191, 8191, 24'h808080, 0);
    send_pixel(8'h81, 8'h80, 8'h80);
    send_pixel(8'hff, 8'hff, 8'hff);
    quiesce();

    // Matches only outside a narrow region
    load_setup(4, 1, 1, 0, 2, 0, 24'h123456, 1);
    send_pixel(8'h12, 8'h34, 8'h56);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h13, 8'h35, 8'h57);
    quiesce();

    // Region top row past the frame bottom
    load_setup(2, 1, 0, 4095, 0, 0, 24'h000000, 255);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    quiesce();

    // Every pixel ends a frame; results held off so the input stalls
    load_setup(1, 1, 0, 0, 0, 0, $urandom_range(0, 24'hffffff), 128);
    @(posedge clk);
    hold_left = 150;
    for (int k = 0; k < 30; k++) begin
      send_random_pixel(20);
      random_items++;
    end
    quiesce();

    // Random phases; registers change mid-frame between them
    while (random_items < 750) begin
      quiesce();
      pick_setup();
      run_phase($urandom_range(10, 50));
    end
    pixel_rest();

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.reports_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
